FILE: rtl/core/b64d_pkg.sv
// b64d_pkg: item types, register map and character decode shared by the
// base64url text decoder and its result queue. No dependencies.

package b64d_pkg;

   // input item
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       status;
      logic       end_of_string;
   } rsp_type;

   // results caused by one input item, up to three, delivered in order
   typedef struct packed {
      logic [23:0] bytes;       // top byte goes out first
      logic [1:0]  count;       // results still to deliver, 0 means none
      logic        byte_valid;
      logic        status;
      logic        end_of_string; // flagged on the final result only
   } bundle_type;

   // decoded character
   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   localparam int unsigned AddrWidth = 3;

   typedef enum logic {
      REG_MAX_CHARS = 1'b0,
      REG_MAX_BYTES = 1'b1
   } reg_index_type;

   localparam logic [7:0] MAX_CHARS_RESET = 8'd11;
   localparam logic [7:0] MAX_BYTES_RESET = 8'd8;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [7:0] CHAR_UNDER   = 8'h5f;

   localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SEXTET_MINUS      = 6'd62;
   localparam logic [5:0] SEXTET_UNDER      = 6'd63;

   localparam logic [7:0] BYTE_COUNT_MAX = 8'hff;

   function automatic sextet_type decode_char(input logic [7:0] c);
      sextet_type s;
      logic [7:0] off_upper;
      logic [7:0] off_lower;
      logic [7:0] off_digit;
      off_upper = c - CHAR_UPPER_A;
      off_lower = c - CHAR_LOWER_A;
      off_digit = c - CHAR_DIGIT_0;
      s = '0;
      priority if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         s.valid = 1'b1;
         s.value = off_upper[5:0];
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         s.valid = 1'b1;
         s.value = SEXTET_LOWER_BASE + off_lower[5:0];
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         s.valid = 1'b1;
         s.value = SEXTET_DIGIT_BASE + off_digit[5:0];
      end else if (c == CHAR_MINUS) begin
         s.valid = 1'b1;
         s.value = SEXTET_MINUS;
      end else if (c == CHAR_UNDER) begin
         s.valid = 1'b1;
         s.value = SEXTET_UNDER;
      end else begin
         s.valid = 1'b0;
         s.value = '0;
      end
      return s;
   endfunction

endpackage

FILE: rtl/core/b64d_out_queue.sv
// b64d_out_queue: holds the results of one decoded item and hands them
// out one per cycle, while rsp_stall is low, through a result register. Depends on b64d_pkg.

module b64d_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  b64d_pkg::bundle_type   push_bundle,
   output logic                   can_push,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output b64d_pkg::rsp_type      rsp_data
);

   b64d_pkg::bundle_type bundle_ff;
   b64d_pkg::rsp_type    rsp_ff;
   logic                 rsp_valid_ff;
   logic                 busy;
   logic                 load;
   b64d_pkg::rsp_type    head;

   assign busy = (bundle_ff.count != 2'd0);
   // result register empty or being taken
   assign load = busy && (!rsp_valid_ff || !rsp_stall);
   // room once the final held result moves to the result register
   assign can_push = !busy || (load && bundle_ff.count == 2'd1);

   always_comb begin
      head.data_byte     = bundle_ff.byte_valid ? bundle_ff.bytes[23:16] : 8'd0;
      head.byte_valid    = bundle_ff.byte_valid;
      head.status        = bundle_ff.status;
      head.end_of_string = bundle_ff.end_of_string && (bundle_ff.count == 2'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bundle_ff.count <= 2'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (push) begin
            bundle_ff <= push_bundle;
         end else if (load) begin
            bundle_ff.count <= bundle_ff.count - 2'd1;
            bundle_ff.bytes <= {bundle_ff.bytes[15:0], 8'd0};
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= head;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/core/base64url_text_decoder.sv
// base64url_text_decoder: top level, string state, character decode and
// register port. Depends on b64d_pkg and b64d_out_queue.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  b64d_pkg::req_type (one character)
//   rsp       out        rsp_valid/rsp_stall  b64d_pkg::rsp_type (byte or end marker)
//   csr       in/out     apb, pready tied 1   max_chars at 0x0, max_bytes at 0x4
//
// one character is decoded in the cycle it is accepted; its zero to three
// results wait in a small queue and leave one per cycle through the result
// register while rsp_stall is low, so the input runs at one item per cycle
// except while rsp_stall holds or an item with two or three results drains
// through the single result port. reset is synchronous and clears the string
// state, the queue and the result valid flag; limits return to 11 chars, 8 bytes.
// req_stall rises only when the queue still holds results after this cycle.

module base64url_text_decoder (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_valid,
   output logic                                req_stall,
   input  b64d_pkg::req_type                   req_data,
   // result items
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output b64d_pkg::rsp_type                   rsp_data,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [b64d_pkg::AddrWidth-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   // limits
   logic [7:0]  max_chars_ff;
   logic [7:0]  max_bytes_ff;

   // string state
   logic [23:0] acc_ff,       acc_in;
   logic [1:0]  pos_ff,       pos_in;
   logic [7:0]  ccount_ff,    ccount_in;
   logic [7:0]  bcount_ff,    bcount_in;
   logic        halted_ff,    halted_in;

   logic                 accept;
   logic                 can_push;
   logic                 push;
   b64d_pkg::bundle_type bundle;
   b64d_pkg::sextet_type sx;
   b64d_pkg::reg_index_type reg_sel;
   logic                 csr_write;

   // decode datapath
   logic [23:0] acc_step;
   logic [23:0] acc_flush;
   logic [7:0]  ccount_inc;
   logic        flush;
   logic        full;
   logic [8:0]  bsum;
   logic [7:0]  bcount_sat;
   logic [8:0]  bdiff;
   logic [1:0]  n_del;

   // ---------------------------------------------------------------
   // register port
   // ---------------------------------------------------------------
   assign pready    = 1'b1;
   assign reg_sel   = b64d_pkg::reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (reg_sel)
         b64d_pkg::REG_MAX_CHARS: prdata = {24'd0, max_chars_ff};
         b64d_pkg::REG_MAX_BYTES: prdata = {24'd0, max_bytes_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= b64d_pkg::MAX_CHARS_RESET;
         max_bytes_ff <= b64d_pkg::MAX_BYTES_RESET;
      end else if (csr_write) begin
         unique case (reg_sel)
            b64d_pkg::REG_MAX_CHARS: max_chars_ff <= pwdata[7:0];
            b64d_pkg::REG_MAX_BYTES: max_bytes_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // character decode
   // ---------------------------------------------------------------
   assign req_stall = !can_push;
   assign accept    = req_valid && !req_stall;

   assign sx         = b64d_pkg::decode_char(req_data.char_code);
   assign acc_step   = {acc_ff[17:0], sx.value};
   // char_count stays below max_chars here, so no wrap
   assign ccount_inc = ccount_ff + 8'd1;
   assign flush      = req_data.last_char || (ccount_inc >= max_chars_ff);
   assign full       = flush || (pos_ff == 2'd3);

   // pad the missing sextets of a partial group with zeros
   always_comb begin
      unique case (pos_ff)
         2'd0:    acc_flush = {acc_step[5:0], 18'd0};
         2'd1:    acc_flush = {acc_step[11:0], 12'd0};
         2'd2:    acc_flush = {acc_step[17:0], 6'd0};
         default: acc_flush = acc_step;
      endcase
   end

   // byte count saturates; bytes past max_bytes are dropped
   assign bsum       = {1'b0, bcount_ff} + 9'd3;
   assign bcount_sat = bsum[8] ? b64d_pkg::BYTE_COUNT_MAX : bsum[7:0];
   assign bdiff      = {1'b0, max_bytes_ff} - {1'b0, bcount_ff};

   always_comb begin
      if (bcount_ff >= max_bytes_ff) begin
         n_del = 2'd0;
      end else if (bdiff >= 9'd3) begin
         n_del = 2'd3;
      end else begin
         n_del = bdiff[1:0];
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      pos_in    = pos_ff;
      ccount_in = ccount_ff;
      bcount_in = bcount_ff;
      halted_in = halted_ff;
      bundle    = '0;

      if (accept) begin
         priority if (halted_ff) begin
            // string already ended: wait for its last character
            if (req_data.last_char) begin
               halted_in = 1'b0;
            end
         end else if (ccount_ff >= max_chars_ff) begin
            // limit reached earlier or lowered: empty end item
            bundle.count         = 2'd1;
            bundle.end_of_string = 1'b1;
            acc_in    = '0;
            pos_in    = '0;
            ccount_in = '0;
            bcount_in = '0;
            halted_in = !req_data.last_char;
         end else if (!sx.valid) begin
            // bad character: error item, drop the rest
            bundle.count         = 2'd1;
            bundle.status        = 1'b1;
            bundle.end_of_string = 1'b1;
            acc_in    = '0;
            pos_in    = '0;
            ccount_in = '0;
            bcount_in = '0;
            halted_in = !req_data.last_char;
         end else if (flush) begin
            bundle.bytes         = acc_flush;
            bundle.byte_valid    = (n_del != 2'd0);
            bundle.count         = (n_del != 2'd0) ? n_del : 2'd1;
            bundle.end_of_string = 1'b1;
            acc_in    = '0;
            pos_in    = '0;
            ccount_in = '0;
            bcount_in = '0;
            halted_in = !req_data.last_char;
         end else begin
            ccount_in = ccount_inc;
            pos_in    = pos_ff + 2'd1;
            if (full) begin
               bundle.bytes      = acc_step;
               bundle.byte_valid = 1'b1;
               bundle.count      = n_del;
               acc_in    = '0;
               bcount_in = bcount_sat;
            end else begin
               acc_in = acc_step;
            end
         end
      end
   end

   assign push = (bundle.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         pos_ff    <= '0;
         ccount_ff <= '0;
         bcount_ff <= '0;
         halted_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         pos_ff    <= pos_in;
         ccount_ff <= ccount_in;
         bcount_ff <= bcount_in;
         halted_ff <= halted_in;
      end
   end

   // ---------------------------------------------------------------
   // result queue and output register
   // ---------------------------------------------------------------
   b64d_out_queue u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (bundle),
      .can_push    (can_push),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for base64url_text_decoder, one character per item in,
// decoded bytes and end markers out. Depends on b64d_pkg and the decoder rtl only.

module tb;

   // clock, reset and the three ports of the block; every input known from time zero
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   b64d_pkg::req_type              req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   b64d_pkg::rsp_type              rsp_data;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [b64d_pkg::AddrWidth-1:0] paddr = '0;
   logic [31:0]                    pwdata = '0;
   logic [31:0]                    prdata;
   logic                           pready;

   // decoder state as the testbench sees it, plus the two limits
   logic [7:0]  lim_chars = b64d_pkg::MAX_CHARS_RESET;
   logic [7:0]  lim_bytes = b64d_pkg::MAX_BYTES_RESET;
   logic [23:0] acc_bits = '0;
   logic [1:0]  grp_pos = '0;
   logic [7:0]  chars_seen = '0;
   logic [7:0]  bytes_seen = '0;
   logic        string_done = 1'b0;

   // bytes and end markers still owed by the block, oldest first
   b64d_pkg::rsp_type due_bytes[$];

   int unsigned mismatch_count = 0;
   int unsigned items_sent = 0;     // every item handed to the block
   bit          calm_mode = 1'b0;   // no gaps on either side while set

   base64url_text_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch in %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
      end
   endtask

   // end of a string: with the last flag the state clears at once,
   // otherwise the rest of the string is dropped until the last flag
   function automatic void close_string(logic fin);
      acc_bits = '0;
      grp_pos = '0;
      chars_seen = '0;
      bytes_seen = '0;
      string_done = !fin;
   endfunction

   // decode one accepted character and queue what it must produce
   function automatic void step_decoder(b64d_pkg::req_type it);
      int                sx;
      int                k;
      int                n;
      int                j;
      logic [1:0]        pos;
      bit                flush;
      bit                full;
      b64d_pkg::rsp_type outs[3];
      b64d_pkg::rsp_type one;
      logic [7:0]        c;
      c = it.char_code;
      n = 0;
      // dropping the tail of an ended string
      if (string_done) begin
         if (it.last_char) close_string(1'b1);
         return;
      end
      // limit already reached (zero or lowered max_chars): empty end item
      if (chars_seen >= lim_chars) begin
         due_bytes.push_back(b64d_pkg::rsp_type'{8'h00, 1'b0, 1'b0, 1'b1});
         close_string(it.last_char);
         return;
      end
      sx = -1;
      if (c >= b64d_pkg::CHAR_UPPER_A && c <= b64d_pkg::CHAR_UPPER_Z)
         sx = int'(c - b64d_pkg::CHAR_UPPER_A);
      else if (c >= b64d_pkg::CHAR_LOWER_A && c <= b64d_pkg::CHAR_LOWER_Z)
         sx = int'(b64d_pkg::SEXTET_LOWER_BASE) + int'(c - b64d_pkg::CHAR_LOWER_A);
      else if (c >= b64d_pkg::CHAR_DIGIT_0 && c <= b64d_pkg::CHAR_DIGIT_9)
         sx = int'(b64d_pkg::SEXTET_DIGIT_BASE) + int'(c - b64d_pkg::CHAR_DIGIT_0);
      else if (c == b64d_pkg::CHAR_MINUS) sx = int'(b64d_pkg::SEXTET_MINUS);
      else if (c == b64d_pkg::CHAR_UNDER) sx = int'(b64d_pkg::SEXTET_UNDER);
      // bad character: error item ends the string
      if (sx < 0) begin
         due_bytes.push_back(b64d_pkg::rsp_type'{8'h00, 1'b0, 1'b1, 1'b1});
         close_string(it.last_char);
         return;
      end
      acc_bits = {acc_bits[17:0], 6'(sx)};
      chars_seen = chars_seen + 8'd1;
      pos = grp_pos;
      flush = it.last_char || chars_seen >= lim_chars;
      if (flush) begin
         // pad the missing sextets with zero
         acc_bits = acc_bits << (6 * (3 - int'(pos)));
         full = 1'b1;
      end else begin
         full = (pos == 2'd3);
         grp_pos = pos + 2'd1;
      end
      if (full) begin
         for (k = 0; k < 3; k++) begin
            if (bytes_seen < lim_bytes) begin
               outs[n] = b64d_pkg::rsp_type'{acc_bits[23 - 8 * k -: 8], 1'b1, 1'b0, 1'b0};
               n++;
            end
            if (bytes_seen != b64d_pkg::BYTE_COUNT_MAX) bytes_seen = bytes_seen + 8'd1;
         end
         acc_bits = '0;
      end
      for (j = 0; j < n; j++) begin
         one = outs[j];
         one.end_of_string = flush && (j == n - 1);
         due_bytes.push_back(one);
      end
      if (flush) begin
         // every byte suppressed: an empty end item stands in
         if (n == 0) due_bytes.push_back(b64d_pkg::rsp_type'{8'h00, 1'b0, 1'b0, 1'b1});
         close_string(it.last_char);
      end
   endfunction

   // send one character, after a random gap, and predict on acceptance
   task automatic put_char(logic [7:0] code, logic fin);
      int unsigned       gap;
      b64d_pkg::req_type it;
      it = {code, fin};
      gap = calm_mode ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall !== 1'b0);
      step_decoder(it);
      items_sent++;
   endtask

   task automatic put_text(string s, logic fin);
      int i;
      for (i = 0; i < s.len(); i++) put_char(s[i], fin && (i == s.len() - 1));
   endtask

   // let every owed item arrive, then wait on for items that owe none
   task automatic settle;
      req_valid <= 1'b0;
      while (due_bytes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // optional write, then a read back that must match the limit now in force
   task automatic csr_access(bit do_write, b64d_pkg::reg_index_type idx, logic [7:0] value);
      logic [7:0] want;
      if (do_write) begin
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= 1'b1;
         paddr <= {idx, 2'b00};
         pwdata <= {24'd0, value};
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (pready !== 1'b1);
         if (idx == b64d_pkg::REG_MAX_CHARS) lim_chars = value;
         else lim_bytes = value;
      end
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      want = (idx == b64d_pkg::REG_MAX_CHARS) ? lim_chars : lim_bytes;
      if (prdata[7:0] !== want) report_mismatch("register read", 32'(want), 32'(prdata[7:0]));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // result side: random stall before each item, then field-wise compare
   initial begin : result_check
      b64d_pkg::rsp_type got;
      b64d_pkg::rsp_type want;
      int unsigned       hold;
      wait (reset === 1'b0);
      forever begin
         hold = calm_mode ? 0 : $urandom_range(0, 10);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got = rsp_data;
         if (due_bytes.size() == 0) begin
            report_mismatch("item with none due", 0, 32'(got));
         end else begin
            want = due_bytes.pop_front();
            if (got.data_byte !== want.data_byte)
               report_mismatch("data_byte", 32'(want.data_byte), 32'(got.data_byte));
            if (got.byte_valid !== want.byte_valid)
               report_mismatch("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
            if (got.status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(got.status));
            if (got.end_of_string !== want.end_of_string)
               report_mismatch("end_of_string", 32'(want.end_of_string),
                               32'(got.end_of_string));
         end
      end
   end

   // limits come up at 11 characters and 8 bytes
   task automatic test_register_reset;
      csr_access(1'b0, b64d_pkg::REG_MAX_CHARS, 8'd0);
      csr_access(1'b0, b64d_pkg::REG_MAX_BYTES, 8'd0);
   endtask

   // all alphabet edges; the 11th character flushes, bytes past 8 are cut,
   // then a dropped character with the last flag clears the string
   task automatic test_alphabet_and_limits;
      put_text("AZaz09-_AZa", 1'b0);
      put_char("x", 1'b1);
   endtask

   // bad characters: error then dropped tail, and an error on the last character
   task automatic test_bad_characters;
      put_char(8'h00, 1'b0);
      put_char(8'hff, 1'b1);
      put_char("=", 1'b1);
   endtask

   // zero character limit gives empty end items; zero byte limit suppresses
   // a flushed group and a full group alike
   task automatic test_zero_limits;
      settle;
      csr_access(1'b1, b64d_pkg::REG_MAX_CHARS, 8'd0);
      put_char("Q", 1'b1);
      put_char("!", 1'b1);
      settle;
      csr_access(1'b1, b64d_pkg::REG_MAX_CHARS, 8'hff);
      csr_access(1'b1, b64d_pkg::REG_MAX_BYTES, 8'd0);
      put_text("AB", 1'b1);
      put_text("ABCDE", 1'b1);
   endtask

   // random strings over a run of limit settings, extremes first
   task automatic test_random_strings;
      int unsigned phase;
      int unsigned budget;
      int unsigned len;
      int unsigned bad_at;
      int unsigned r;
      int unsigned i;
      logic [7:0]  mc;
      logic [7:0]  mb;
      logic [7:0]  code;
      logic [5:0]  sx;
      phase = 0;
      while (items_sent < 220) begin
         case (phase)
            0: begin mc = 8'hff; mb = 8'hff; budget = 40; end
            1: begin mc = 8'd1; mb = 8'd0; budget = 8; end
            2: begin mc = 8'd0; mb = 8'($urandom_range(0, 255)); budget = 4; end
            3: begin mc = 8'd4; mb = 8'hff; budget = 16; end
            default: begin
               r = $urandom_range(0, 9);
               mc = (r < 7) ? 8'($urandom_range(1, 24)) :
                    (r < 9) ? 8'($urandom_range(25, 80)) : 8'($urandom_range(0, 255));
               mb = $urandom_range(0, 1) ? 8'($urandom_range(0, 24)) :
                    8'($urandom_range(0, 255));
               budget = 30;
            end
         endcase
         budget = budget + items_sent;
         settle;
         // every fourth phase runs with no gaps on either side
         calm_mode = (phase % 4 == 2);
         csr_access(1'b1, b64d_pkg::REG_MAX_CHARS, mc);
         csr_access(1'b1, b64d_pkg::REG_MAX_BYTES, mb);
         while (items_sent < budget && items_sent < 220) begin
            r = $urandom_range(0, 15);
            if (r == 0) begin
               // noise: any code, any flag
               put_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
               r = $urandom_range(0, 19);
               len = (r < 14) ? $urandom_range(1, 12) :
                     (r < 19) ? $urandom_range(13, 30) : $urandom_range(31, 90);
               bad_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : len;
               r = $urandom_range(0, 7);   // one string in eight has no last flag
               for (i = 0; i < len; i++) begin
                  sx = 6'($urandom_range(0, 63));
                  if (sx < b64d_pkg::SEXTET_LOWER_BASE)
                     code = b64d_pkg::CHAR_UPPER_A + sx;
                  else if (sx < b64d_pkg::SEXTET_DIGIT_BASE)
                     code = b64d_pkg::CHAR_LOWER_A + (sx - b64d_pkg::SEXTET_LOWER_BASE);
                  else if (sx < b64d_pkg::SEXTET_MINUS)
                     code = b64d_pkg::CHAR_DIGIT_0 + (sx - b64d_pkg::SEXTET_DIGIT_BASE);
                  else if (sx == b64d_pkg::SEXTET_MINUS)
                     code = b64d_pkg::CHAR_MINUS;
                  else
                     code = b64d_pkg::CHAR_UNDER;
                  if (i == bad_at) code = 8'($urandom_range(0, 255));
                  put_char(code, (i == len - 1) && (r != 0));
               end
            end
         end
         phase++;
      end
      calm_mode = 1'b0;
   endtask

   initial begin : main_sequence
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_register_reset;
      test_alphabet_and_limits;
      test_bad_characters;
      test_zero_limits;
      test_random_strings;
      settle;
      if (mismatch_count == 0 && due_bytes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin : watchdog
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
